>>> rtl/fct_pkg.sv
// Shared types and constants for the fraction coprimality test block.
`default_nettype none

package fct_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int SHIFT_W    = $clog2(DATA_WIDTH) + 1;

  typedef logic [DATA_WIDTH-1:0] fct_word_t;
  typedef logic [SHIFT_W-1:0]    fct_shift_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIP,
    ST_ODDA,
    ST_REDUCE,
    ST_FINISH
  } fct_state_t;

  typedef struct packed {
    logic load;
    logic strip;
    logic shift_a;
    logic shift_b;
    logic reduce;
    logic store_out;
  } fct_cmd_t;

  typedef struct packed {
    logic zero_op;
    logic both_even;
    logic a_even;
    logic b_even;
    logic diff_zero;
  } fct_status_t;

endpackage

`default_nettype wire

>>> rtl/fct_if.sv
// Request and result channel interfaces of the fraction coprimality test block.
`default_nettype none

interface fct_in_if
  import fct_pkg::*;
  ;
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] numerator;
  logic signed [DATA_WIDTH-1:0] denominator;

  modport source (output valid, numerator, denominator, input ready);
  modport sink   (input valid, numerator, denominator, output ready);
endinterface

interface fct_out_if
  import fct_pkg::*;
  ;
  logic                  valid;
  logic                  ready;
  logic                  in_lowest_terms;
  logic [DATA_WIDTH-1:0] common_divisor;
  logic                  invalid;

  modport source (output valid, in_lowest_terms, common_divisor, invalid, input ready);
  modport sink   (input valid, in_lowest_terms, common_divisor, invalid, output ready);
endinterface

`default_nettype wire

>>> rtl/fraction_coprime_test_top.sv
// Top level of the fraction coprimality test: controller, datapath and assertions.
`default_nettype none

// Takes a signed numerator and denominator per request and returns the GCD of their
// magnitudes, a flag that is set when that GCD is one, and an invalid flag when either
// operand is zero (the GCD and the lowest-terms flag are then zero). One request is
// worked at a time with a binary shift-and-subtract GCD that does one shift or one
// compare-and-subtract step per cycle. A zero operand goes from the accepting cycle
// straight to the store of the result. Otherwise the request first strips the common
// factors of two, then shifts the numerator until it is odd, then shifts the other
// working value and does the subtract steps until the two are equal, and then stores
// the result. The store waits while an earlier result is still pending. The result
// sits in an output register, so the next request is taken while an earlier result
// still waits to be read.
module fraction_coprime_test_top
  import fct_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  fct_in_if.sink   in_chan,
  fct_out_if.source out_chan
);

  fct_cmd_t    cmd;
  fct_status_t status;
  fct_state_t  state;

  fct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd),
    .state     (state)
  );

  fct_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .numerator       (in_chan.numerator),
    .denominator     (in_chan.denominator),
    .in_lowest_terms (out_chan.in_lowest_terms),
    .common_divisor  (out_chan.common_divisor),
    .invalid         (out_chan.invalid)
  );

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store_out |-> (!out_chan.valid || out_chan.ready))
    else $error("result register overwritten while still pending");

  // An invalid result carries a zero divisor and a cleared lowest-terms flag.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.invalid) |->
      (out_chan.common_divisor == '0 && !out_chan.in_lowest_terms))
    else $error("invalid result with nonzero fields");

  // The lowest-terms flag agrees with the reported divisor.
  a_lowest_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |->
      (out_chan.in_lowest_terms == (out_chan.common_divisor == DATA_WIDTH'(1))))
    else $error("lowest-terms flag disagrees with divisor");

  // After a request is accepted no other is taken until the result is stored.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (!in_chan.ready && state != ST_IDLE))
    else $error("request accepted while another is in progress");

endmodule

`default_nettype wire

>>> rtl/fct_dp.sv
// Datapath of the binary GCD: working values, factor-of-two count and result register.
`default_nettype none

module fct_dp
  import fct_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire fct_cmd_t                     cmd,
  output fct_status_t                       status,
  input  wire logic signed [DATA_WIDTH-1:0] numerator,
  input  wire logic signed [DATA_WIDTH-1:0] denominator,
  output logic                              in_lowest_terms,
  output logic [DATA_WIDTH-1:0]             common_divisor,
  output logic                              invalid
);

  fct_word_t  a_r, a_nxt;
  fct_word_t  b_r, b_nxt;
  fct_shift_t k_r, k_nxt;
  logic       inv_r, inv_nxt;

  fct_word_t  div_out_r;
  logic       lowest_out_r;
  logic       inv_out_r;

  fct_word_t  mag_n, mag_d;
  fct_word_t  diff;
  fct_word_t  gcd_val;
  logic       a_gt_b;

  // The most negative operand maps to 2^(DATA_WIDTH-1), which fits unsigned.
  assign mag_n = numerator[DATA_WIDTH-1]   ? fct_word_t'(-numerator)   : fct_word_t'(numerator);
  assign mag_d = denominator[DATA_WIDTH-1] ? fct_word_t'(-denominator) : fct_word_t'(denominator);

  assign a_gt_b  = a_r > b_r;
  assign diff    = a_gt_b ? (a_r - b_r) : (b_r - a_r);
  assign gcd_val = a_r << k_r;

  assign status.zero_op   = (mag_n == '0) || (mag_d == '0);
  assign status.both_even = ~(a_r[0] | b_r[0]);
  assign status.a_even    = ~a_r[0];
  assign status.b_even    = ~b_r[0];
  assign status.diff_zero = (a_r == b_r);

  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    k_nxt   = k_r;
    inv_nxt = inv_r;
    if (cmd.load) begin
      a_nxt   = status.zero_op ? '0 : mag_n;
      b_nxt   = status.zero_op ? '0 : mag_d;
      k_nxt   = '0;
      inv_nxt = status.zero_op;
    end else if (cmd.strip) begin
      a_nxt = a_r >> 1;
      b_nxt = b_r >> 1;
      k_nxt = k_r + fct_shift_t'(1);
    end else if (cmd.shift_a) begin
      a_nxt = a_r >> 1;
    end else if (cmd.shift_b) begin
      b_nxt = b_r >> 1;
    end else if (cmd.reduce) begin
      // Keep the smaller value as the odd part and replace the other by the difference.
      a_nxt = a_gt_b ? b_r : a_r;
      b_nxt = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r   <= '0;
      b_r   <= '0;
      k_r   <= '0;
      inv_r <= 1'b0;
    end else begin
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      k_r   <= k_nxt;
      inv_r <= inv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_out) begin
      div_out_r    <= inv_r ? '0 : gcd_val;
      lowest_out_r <= ~inv_r && (gcd_val == fct_word_t'(1));
      inv_out_r    <= inv_r;
    end
  end

  assign in_lowest_terms = lowest_out_r;
  assign common_divisor  = div_out_r;
  assign invalid         = inv_out_r;

endmodule

`default_nettype wire

>>> rtl/fct_ctrl.sv
// Controller state machine that sequences the binary GCD steps and the result handshake.
`default_nettype none

module fct_ctrl
  import fct_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire fct_status_t status,
  output fct_cmd_t         cmd,
  output fct_state_t       state
);

  fct_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = status.zero_op ? ST_FINISH : ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (status.both_even) begin
          cmd.strip = 1'b1;
        end else begin
          state_nxt = ST_ODDA;
        end
      end
      ST_ODDA: begin
        if (status.a_even) begin
          cmd.shift_a = 1'b1;
        end else begin
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (status.b_even) begin
          cmd.shift_b = 1'b1;
        end else begin
          cmd.reduce = 1'b1;
          if (status.diff_zero) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        // The result register can take a new value once the old one is gone or leaving.
        if (!out_valid_r || out_ready) begin
          cmd.store_out = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.store_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign state     = state_r;

endmodule

`default_nettype wire

>>> tb/fraction_coprime_test_top_test.sv
// Testbench for the fraction coprimality test block: directed and random GCD requests.
`timescale 1ns / 1ps

module fraction_coprime_test_top_test;
  import fct_pkg::*;

  localparam int        CLK_PERIOD  = 12;
  localparam int        STALL_LIMIT = 3000;
  localparam int        TAIL_CYCLES = 200;
  localparam int        MAX_REPORTS = 10;
  localparam fct_word_t MOST_NEG    = 32'h8000_0000;
  localparam fct_word_t MOST_POS    = 32'h7FFF_FFFF;

  typedef struct packed {
    logic      in_lowest_terms;
    fct_word_t common_divisor;
    logic      invalid;
  } gcd_result_t;

  logic clk;
  logic rst_n;

  fct_in_if  in_chan ();
  fct_out_if out_chan ();

  fraction_coprime_test_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  gcd_result_t gcd_expected[$];
  gcd_result_t gcd_want;
  int          mismatch_count = 0;
  int          quiet_cycles   = 0;
  bit          idle_enable    = 1'b1;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // GCD of the operand magnitudes, computed by Euclid's remainder method.
  function automatic gcd_result_t predict_gcd(input fct_word_t num, input fct_word_t den);
    fct_word_t   mag_n;
    fct_word_t   mag_d;
    fct_word_t   rem;
    gcd_result_t res;
    mag_n = num[DATA_WIDTH-1] ? (~num + 1'b1) : num;
    mag_d = den[DATA_WIDTH-1] ? (~den + 1'b1) : den;
    res = '0;
    if (mag_n == '0 || mag_d == '0) begin
      res.invalid = 1'b1;
      return res;
    end
    while (mag_d != '0) begin
      rem   = mag_n % mag_d;
      mag_n = mag_d;
      mag_d = rem;
    end
    res.common_divisor  = mag_n;
    res.in_lowest_terms = (mag_n == 1);
    return res;
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic send_request(input fct_word_t num, input fct_word_t den);
    while (idle_enable && $urandom_range(99) < 30) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.numerator   <= num;
    in_chan.denominator <= den;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    gcd_expected.push_back(predict_gcd(num, den));
  endtask

  task automatic wait_for_results();
    in_chan.valid <= 1'b0;
    while (gcd_expected.size() != 0) @(posedge clk);
  endtask

  // Mostly pairs that share a factor, since plain random pairs are usually coprime.
  task automatic random_pair(output fct_word_t num, output fct_word_t den);
    fct_word_t   factor;
    int unsigned shift;
    fct_word_t   specials[7];
    specials = '{32'd0, 32'd1, 32'hFFFF_FFFF, MOST_NEG, MOST_POS, 32'h4000_0000, 32'hC000_0000};
    case ($urandom_range(9))
      0: begin
        num = $urandom;
        den = $urandom;
      end
      1, 2: begin
        factor = $urandom_range(65535, 1);
        num    = factor * $urandom_range(32767, 1);
        den    = factor * $urandom_range(32767, 1);
      end
      3, 4: begin
        shift = $urandom_range(31);
        num   = $urandom << shift;
        den   = $urandom << shift;
      end
      5: begin
        num = $urandom;
        den = '0;
        if ($urandom_range(1)) begin
          den = num;
          num = '0;
        end
      end
      6: begin
        num = specials[$urandom_range(6)];
        den = ($urandom_range(1)) ? specials[$urandom_range(6)] : fct_word_t'($urandom);
      end
      7: begin
        num = $urandom_range(65535, 1);
        den = num * $urandom_range(30000, 1);
      end
      default: begin
        factor = $urandom_range(30, 2);
        shift  = $urandom_range(12);
        num    = (factor * $urandom_range(1 << 18, 1)) << shift;
        den    = (factor * $urandom_range(1 << 18, 1)) << $urandom_range(12);
      end
    endcase
    if ($urandom_range(1)) num = -num;
    if ($urandom_range(1)) den = -den;
  endtask

  task automatic send_random(input int count);
    fct_word_t num;
    fct_word_t den;
    repeat (count) begin
      random_pair(num, den);
      send_request(num, den);
    end
  endtask

  task automatic test_zero_operands();
    send_request(32'd0, 32'd5);
    send_request(32'hFFFF_FFF9, 32'd0);
    send_request(32'd0, 32'd0);
    send_request(32'd0, MOST_NEG);
  endtask

  // The most negative value has magnitude two to the 31st, which is also the widest GCD.
  task automatic test_extreme_values();
    send_request(MOST_NEG, MOST_NEG);
    send_request(MOST_POS, MOST_POS);
    send_request(MOST_NEG, MOST_POS);
    send_request(MOST_POS, MOST_NEG);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'd1, 32'd1);
    send_request(32'hFFFF_FFFF, MOST_NEG);
    send_request(MOST_NEG, 32'hFFFF_FFFE);
    send_request(32'd1, MOST_POS);
    send_request(32'hC000_0000, 32'h4000_0000);
  endtask

  task automatic test_common_factors();
    send_request(32'd12, -32'sd18);
    send_request(-32'sd35, 32'd64);
    send_request(32'h4000_0000, 32'd3 << 20);
    send_request(32'd6, 32'd4);
    send_request(32'd7, 32'd7 * 32'd13);
    send_request(32'd9973 * 32'd2, -32'sd9973 * 32'sd3);
    send_request(32'd97, 32'd89);
  endtask

  task automatic test_random_mix(input int count);
    idle_enable = 1'b1;
    send_random(count);
  endtask

  task automatic test_without_idling(input int count);
    idle_enable = 1'b0;
    send_random(count);
    idle_enable = 1'b1;
  endtask

  task automatic test_pause_until_drained(input int bursts, input int per_burst);
    repeat (bursts) begin
      send_random(per_burst);
      wait_for_results();
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (gcd_expected.size() == 0) begin
        note_failure($sformatf("result with no request pending: gcd=%0d lowest=%0b invalid=%0b",
                               out_chan.common_divisor, out_chan.in_lowest_terms,
                               out_chan.invalid));
      end else begin
        gcd_want = gcd_expected.pop_front();
        if (out_chan.common_divisor !== gcd_want.common_divisor ||
            out_chan.in_lowest_terms !== gcd_want.in_lowest_terms ||
            out_chan.invalid !== gcd_want.invalid) begin
          note_failure($sformatf(
            "mismatch: gcd exp %0d got %0d, lowest exp %0b got %0b, invalid exp %0b got %0b",
            gcd_want.common_divisor, out_chan.common_divisor,
            gcd_want.in_lowest_terms, out_chan.in_lowest_terms,
            gcd_want.invalid, out_chan.invalid));
        end
      end
    end
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= !idle_enable || ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.numerator   = '0;
    in_chan.denominator = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_operands();
    test_extreme_values();
    test_common_factors();
    test_random_mix(200);
    test_without_idling(120);
    test_pause_until_drained(10, 13);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && gcd_expected.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
